[hw/rtl/aev_pkg.sv]
// Shared types, constants and register codes for the adaptive energy VAD.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package aev_pkg;

    // Chunk size limit and the widths that follow from it
    localparam int MAX_CHUNK_SAMPLES = 2048;
    localparam int CNT_W   = $clog2(MAX_CHUNK_SAMPLES + 1);   // holds the limit itself
    localparam int SQ_W    = 32;                              // square of a 16-bit magnitude
    localparam int SUM_W   = 31 + $clog2(MAX_CHUNK_SAMPLES);  // sum of squares over a chunk
    localparam int FRAC_SH = 16;                              // sum scaled to Q.16 before divide
    localparam int NUM_W   = SUM_W + FRAC_SH;                 // dividend width
    localparam int WDEN_W  = 9;                               // warm-up divisor (count + 1)
    localparam int DEN_W   = (CNT_W > WDEN_W) ? CNT_W : WDEN_W;
    localparam int ITER_W  = $clog2(NUM_W);

    // Mean square in Q.16 stays below 2^47, so its root fits 24 bits
    localparam int RAD_W   = 48;
    localparam int ALU_W   = RAD_W;
    localparam int LVL_W   = 24;
    localparam int K_W     = 8;
    localparam int PROD_W  = LVL_W + K_W;

    localparam logic [LVL_W-1:0] ONE_Q8    = LVL_W'(256);
    localparam logic [3:0]       LOUD_MAX  = 4'hF;
    localparam logic [7:0]       RUN_MAX   = 8'hFF;

    // Register reset values
    localparam logic [7:0] RST_K_HIGH      = 8'd64;
    localparam logic [7:0] RST_K_LOW       = 8'd32;
    localparam logic [3:0] RST_TRIGGER     = 4'd2;
    localparam logic [7:0] RST_WARMUP      = 8'd25;
    localparam logic [7:0] RST_SILENCE     = 8'd15;
    localparam logic [7:0] RST_MAX_COLLECT = 8'd50;
    localparam logic [3:0] RST_RISE_SHIFT  = 4'd6;
    localparam logic [3:0] RST_FALL_SHIFT  = 4'd3;

    typedef enum logic [2:0] {
        CFG_K_HIGH      = 3'd0,
        CFG_K_LOW       = 3'd1,
        CFG_TRIGGER     = 3'd2,
        CFG_WARMUP      = 3'd3,
        CFG_SILENCE     = 3'd4,
        CFG_MAX_COLLECT = 3'd5,
        CFG_RISE_SHIFT  = 3'd6,
        CFG_FALL_SHIFT  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] k_high;
        logic [7:0] k_low;
        logic [3:0] trigger_chunks;
        logic [7:0] warmup_chunks;
        logic [7:0] silence_chunks;
        logic [7:0] max_collect_chunks;
        logic [3:0] rise_shift;
        logic [3:0] fall_shift;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] sample_word;
        logic               chunk_last;
    } t_in_item;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] noise_floor;
        logic             seeded;
        logic             collecting;
        logic             utterance_done;
    } t_out_item;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [CNT_W-1:0] count;
    } t_acc_stat;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             ge;
        logic [ALU_W-1:0] diff;
    } t_alu_rsp;

    typedef struct packed {
        logic in_accept;
        logic chunk_last;
        logic out_free;
    } t_seq_ctl;

    typedef struct packed {
        logic idle;
        logic acc_clear;
        logic push;
    } t_seq_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_FLOOR_SEL,
        ST_WDIV,
        ST_FUPD,
        ST_FCLAMP,
        ST_PROD,
        ST_HYST,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/adaptive_energy_vad.sv]
// Adaptive energy VAD top level. Depends on aev_pkg, aev_accum, aev_seq.
// Samples that do not close a chunk: one transfer per cycle, squares summed in two stages.
// A chunk-closing sample starts 58 restoring-divide and 24 root steps (plus 24 divide steps
// in warm-up) on the shared subtractor; input ready stays low until the result is pushed
// into the output register, and the push waits while that register is full.
// Reset (synchronous, active low) clears sums, floor, counters and loads register defaults.
`default_nettype none

module adaptive_energy_vad import aev_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Sample channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_data,
    // Result channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_data,
    // Register write channel
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_seq_ctl  w_ctl;
    t_seq_stat w_stat;
    t_acc_stat w_acc;
    t_out_item w_result;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      w_in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_stat.idle;
    assign w_in_accept = i_in_valid && w_stat.idle;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k_high             <= RST_K_HIGH;
            r_cfg.k_low              <= RST_K_LOW;
            r_cfg.trigger_chunks     <= RST_TRIGGER;
            r_cfg.warmup_chunks      <= RST_WARMUP;
            r_cfg.silence_chunks     <= RST_SILENCE;
            r_cfg.max_collect_chunks <= RST_MAX_COLLECT;
            r_cfg.rise_shift         <= RST_RISE_SHIFT;
            r_cfg.fall_shift         <= RST_FALL_SHIFT;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_K_HIGH:      r_cfg.k_high             <= i_cfg_data;
                CFG_K_LOW:       r_cfg.k_low              <= i_cfg_data;
                CFG_TRIGGER:     r_cfg.trigger_chunks     <= i_cfg_data[3:0];
                CFG_WARMUP:      r_cfg.warmup_chunks      <= i_cfg_data;
                CFG_SILENCE:     r_cfg.silence_chunks     <= i_cfg_data;
                CFG_MAX_COLLECT: r_cfg.max_collect_chunks <= i_cfg_data;
                CFG_RISE_SHIFT:  r_cfg.rise_shift         <= i_cfg_data[3:0];
                CFG_FALL_SHIFT:  r_cfg.fall_shift         <= i_cfg_data[3:0];
            endcase
        end
    end

    aev_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_in_accept),
        .i_sample_word (i_in_data.sample_word),
        .i_clear       (w_stat.acc_clear),
        .o_acc         (w_acc)
    );

    assign w_ctl.in_accept  = w_in_accept;
    assign w_ctl.chunk_last = i_in_data.chunk_last;
    assign w_ctl.out_free   = !r_out_valid || i_out_ready;

    aev_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_ctl    (w_ctl),
        .i_acc    (w_acc),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.push) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

[hw/rtl/aev_accum.sv]
// Per-sample square-and-accumulate stage with the chunk sample counter.
// Depends on aev_pkg.
`default_nettype none

module aev_accum import aev_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic signed [31:0] i_sample_word,
    input  wire logic               i_clear,
    output t_acc_stat               o_acc
);

    logic [15:0]      w_raw;
    logic [15:0]      w_mag;
    logic             w_keep;
    logic [SQ_W-1:0]  r_sq;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;

    // Upper half of the word is the sample; take its magnitude
    assign w_raw  = i_sample_word[31:16];
    assign w_mag  = w_raw[15] ? (16'd0 - w_raw) : w_raw;
    assign w_keep = r_cnt < CNT_W'(MAX_CHUNK_SAMPLES);

    // Square is registered, then folded into the sum the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq  <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            r_sq  <= (i_accept && w_keep) ? (SQ_W'(w_mag) * SQ_W'(w_mag)) : '0;
            if (i_clear) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= r_sum + SUM_W'(r_sq);
                if (i_accept && w_keep) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    // Sum including the square still in flight
    assign o_acc.total = r_sum + SUM_W'(r_sq);
    assign o_acc.count = r_cnt;

endmodule

`default_nettype wire

[hw/rtl/aev_alu.sv]
// Shared compare-subtract unit used by the divide, root, floor and threshold steps.
// Depends on aev_pkg.
`default_nettype none

module aev_alu import aev_pkg::*; (
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic [ALU_W:0] w_d;

    // One wide subtract; the borrow gives a >= b
    assign w_d        = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.ge   = ~w_d[ALU_W];
    assign o_rsp.diff = w_d[ALU_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/aev_seq.sv]
// Chunk-end sequencer: divide, root, noise floor update and hysteresis,
// all stepping through the shared aev_alu. Depends on aev_pkg and aev_alu.
`default_nettype none

module aev_seq import aev_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire t_seq_ctl  i_ctl,
    input  wire t_acc_stat i_acc,
    output t_seq_stat      o_stat,
    output t_out_item      o_result
);

    t_state r_state, n_state;

    // Iteration registers
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [ITER_W-1:0] r_iter;
    logic [RAD_W-1:0]  r_rad;
    logic [RAD_W-1:0]  r_res;
    logic [RAD_W-1:0]  r_bit;
    logic [LVL_W-1:0]  r_delta;
    logic              r_neg;
    logic              r_warm;
    logic              r_seed_now;
    logic [PROD_W-1:0] r_prod;

    // Detector state
    logic [LVL_W-1:0]  r_level;
    logic [LVL_W-1:0]  r_floor;
    logic [LVL_W-1:0]  r_seed;
    logic [7:0]        r_wcnt;
    logic              r_collect;
    logic [3:0]        r_loud;
    logic [7:0]        r_quiet;
    logic [7:0]        r_collected;
    logic              r_seeded;
    logic              r_done;

    t_alu_req          w_req;
    t_alu_rsp          w_rsp;
    logic [DEN_W:0]    w_trial;
    logic [RAD_W-1:0]  n_res;
    logic [LVL_W-1:0]  w_mag;
    logic [LVL_W-1:0]  w_upd;
    logic [LVL_W-1:0]  w_f1;
    logic              w_seeded;
    logic [3:0]        n_loud;
    logic [7:0]        n_quiet;
    logic [7:0]        n_collected;

    aev_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_trial  = {r_rem, r_num[NUM_W-1]};
    assign w_seeded = r_wcnt >= i_cfg.warmup_chunks;

    // Operand select for the shared unit
    always_comb begin
        w_req.a = '0;
        w_req.b = '0;
        unique case (r_state)
            ST_DIV, ST_WDIV: begin
                w_req.a = ALU_W'(w_trial);
                w_req.b = ALU_W'(r_den);
            end
            ST_ROOT: begin
                w_req.a = r_rad;
                w_req.b = r_res | r_bit;
            end
            ST_FLOOR_SEL: begin
                w_req.a = ALU_W'(r_level);
                w_req.b = ALU_W'(r_floor);
            end
            ST_HYST: begin
                w_req.a = ALU_W'({r_level, 4'b0000});
                w_req.b = ALU_W'(r_prod);
            end
            default: begin
                w_req.a = '0;
                w_req.b = '0;
            end
        endcase
    end

    // Root step result; level - floor magnitude; floor step and 1.0 clamp
    assign n_res = w_rsp.ge ? ((r_res >> 1) | r_bit) : (r_res >> 1);
    assign w_mag = w_rsp.ge ? w_rsp.diff[LVL_W-1:0] : (LVL_W'(0) - w_rsp.diff[LVL_W-1:0]);
    assign w_upd = r_warm ? r_num[LVL_W-1:0] : r_delta;
    assign w_f1  = (r_floor < ONE_Q8) ? ONE_Q8 : r_floor;

    // Hysteresis run counters
    always_comb begin
        n_loud      = '0;
        n_quiet     = '0;
        n_collected = (r_collected != RUN_MAX) ? r_collected + 8'd1 : r_collected;
        if (w_rsp.ge) begin
            n_loud = (r_loud != LOUD_MAX) ? r_loud + 4'd1 : r_loud;
        end else begin
            n_quiet = (r_quiet != RUN_MAX) ? r_quiet + 8'd1 : r_quiet;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.in_accept && i_ctl.chunk_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:      n_state = ST_DIV;
            ST_DIV: begin
                if (r_iter == '0) begin
                    n_state = ST_ROOT_INIT;
                end
            end
            ST_ROOT_INIT: n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_bit[0]) begin
                    n_state = ST_FLOOR_SEL;
                end
            end
            ST_FLOOR_SEL: begin
                priority if (!w_seeded) begin
                    n_state = ST_WDIV;
                end else if (!r_collect) begin
                    n_state = ST_FUPD;
                end else begin
                    n_state = ST_FCLAMP;
                end
            end
            ST_WDIV: begin
                if (r_iter == '0) begin
                    n_state = ST_FUPD;
                end
            end
            ST_FUPD:      n_state = ST_FCLAMP;
            ST_FCLAMP:    n_state = w_seeded ? ST_PROD : ST_OUT;
            ST_PROD:      n_state = ST_HYST;
            ST_HYST:      n_state = ST_OUT;
            ST_OUT: begin
                if (i_ctl.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_stat.idle      = r_state == ST_IDLE;
        o_stat.acc_clear = r_state == ST_LOAD;
        o_stat.push      = (r_state == ST_OUT) && i_ctl.out_free;
    end

    assign o_result.level          = r_level;
    assign o_result.noise_floor    = r_floor;
    assign o_result.seeded         = r_seeded;
    assign o_result.collecting     = r_collect;
    assign o_result.utterance_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath, stepped by state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor     <= '0;
            r_seed      <= '0;
            r_wcnt      <= '0;
            r_collect   <= 1'b0;
            r_loud      <= '0;
            r_quiet     <= '0;
            r_collected <= '0;
            r_seeded    <= 1'b0;
            r_done      <= 1'b0;
            r_level     <= '0;
        end else begin
            unique case (r_state)
                // Latch chunk sum scaled by 2^16 and its sample count
                ST_LOAD: begin
                    r_num  <= {i_acc.total, {FRAC_SH{1'b0}}};
                    r_den  <= (i_acc.count == '0) ? DEN_W'(1) : DEN_W'(i_acc.count);
                    r_rem  <= '0;
                    r_iter <= ITER_W'(NUM_W - 1);
                end
                // Restoring divide, one quotient bit per cycle
                ST_DIV, ST_WDIV: begin
                    r_rem  <= w_rsp.ge ? w_rsp.diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                    r_num  <= {r_num[NUM_W-2:0], w_rsp.ge};
                    r_iter <= r_iter - ITER_W'(1);
                end
                ST_ROOT_INIT: begin
                    r_rad <= RAD_W'(r_num);
                    r_res <= '0;
                    r_bit <= RAD_W'(1) << (RAD_W - 2);
                end
                // Digit-by-digit root, two radicand bits per cycle
                ST_ROOT: begin
                    if (w_rsp.ge) begin
                        r_rad <= w_rsp.diff;
                    end
                    r_res   <= n_res;
                    r_bit   <= r_bit >> 2;
                    r_level <= n_res[LVL_W-1:0];
                end
                // Pick warm-up mean or EMA step
                ST_FLOOR_SEL: begin
                    r_neg      <= ~w_rsp.ge;
                    r_warm     <= ~w_seeded;
                    r_seed_now <= 1'b0;
                    r_delta    <= w_mag >> (w_rsp.ge ? i_cfg.rise_shift : i_cfg.fall_shift);
                    r_num      <= {w_mag, {(NUM_W - LVL_W){1'b0}}};
                    r_rem      <= '0;
                    r_den      <= DEN_W'({1'b0, r_wcnt} + 9'd1);
                    r_iter     <= ITER_W'(LVL_W - 1);
                end
                ST_FUPD: begin
                    r_floor <= r_neg ? (r_floor - w_upd) : (r_floor + w_upd);
                    if (r_warm) begin
                        r_wcnt     <= r_wcnt + 8'd1;
                        r_seed_now <= (r_wcnt + 8'd1) == i_cfg.warmup_chunks;
                    end
                end
                // Clamp to 1.0 and to the warm-up seed
                ST_FCLAMP: begin
                    if (r_seed_now) begin
                        r_seed  <= w_f1;
                        r_floor <= w_f1;
                    end else begin
                        r_floor <= (w_f1 < r_seed) ? r_seed : w_f1;
                    end
                    r_seeded <= w_seeded;
                    r_done   <= 1'b0;
                end
                ST_PROD: begin
                    r_prod <= r_floor * (r_collect ? i_cfg.k_low : i_cfg.k_high);
                end
                // Hysteresis: level*16 against floor*k
                ST_HYST: begin
                    if (!r_collect) begin
                        if (n_loud >= i_cfg.trigger_chunks) begin
                            r_collect   <= 1'b1;
                            r_quiet     <= '0;
                            r_collected <= '0;
                            r_loud      <= '0;
                        end else begin
                            r_loud <= n_loud;
                        end
                    end else begin
                        r_collected <= n_collected;
                        r_quiet     <= n_quiet;
                        if ((n_quiet >= i_cfg.silence_chunks) ||
                            (n_collected >= i_cfg.max_collect_chunks)) begin
                            r_collect <= 1'b0;
                            r_done    <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Floor reported with a result is never below 1.0
    a_floor_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.push |-> (o_result.noise_floor >= ONE_Q8))
        else $error("noise floor below 1.0 at result");

    // An utterance end leaves the detector seeded and idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.push && o_result.utterance_done) |-> (o_result.seeded && !o_result.collecting))
        else $error("utterance end while still collecting or not seeded");

    // Root result stays within the level range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.push |-> (o_result.level <= LVL_W'(24'h80_0000)))
        else $error("level out of range");

    // Divide keeps iterating until its counter runs out
    a_div_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_iter != '0)) |=> (r_state == ST_DIV))
        else $error("divide left early");

endmodule

`default_nettype wire
